FILE: src/lmcof_pkg.sv
// ----------------------------------------------------------------------------
// lmcof_pkg: shared types and constants of the label mask filter
// Holds the token that carries one tick through the mask stages, the
// configuration register indexes and the fixed field widths.
// ----------------------------------------------------------------------------
package lmcof_pkg;

  localparam int COLOR_W   = 24;
  localparam int SIZE_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int STAGE_CNT = 3;
  localparam int MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LABEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

  localparam logic [COLOR_W-1:0] WHITE_COLOR = 24'hFFFFFF;
  localparam logic [SIZE_W-1:0]  RESET_SIZE  = 11'd1024;

  // One tick of the frame as it moves down the stages.
  // act[k]/first[k]: stage k input is live / at its first position;
  // index STAGE_CNT refers to the final result stream.
  typedef struct packed {
    logic [STAGE_CNT:0]  act;
    logic [STAGE_CNT:0]  first;
    logic                outv;
    logic                last;
    logic                mbit;
    logic [SIZE_W-1:0]   w;
    logic [SIZE_W-1:0]   h;
    logic [COLOR_W-1:0]  label;
  } tok_t;

endpackage

FILE: src/lmcof_front.sv
// ----------------------------------------------------------------------------
// lmcof_front: configuration, frame position and tick tokens
// Takes input transfers, tracks the tick position of the frame, latches the
// frame settings at frame start and issues one token per live tick.
// ----------------------------------------------------------------------------
module lmcof_front import lmcof_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int GROW_RADIUS   = 3,
  parameter int SHRINK_RADIUS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [COLOR_W-1:0]   in_pixel_color,
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output tok_t                 tok
);

  localparam int LAG_SUM = 2 * GROW_RADIUS + SHRINK_RADIUS;
  localparam int TW = $clog2(LAG_SUM * (MAX_WIDTH + 1) + MAX_WIDTH * MAX_HEIGHT + 1);

  logic [COLOR_W-1:0] label_r;
  logic [SIZE_W-1:0]  width_r, height_r;
  logic [TW-1:0]      t_r, t_nxt;
  logic [COLOR_W-1:0] f_label_r;
  logic [SIZE_W-1:0]  f_w_r, f_h_r;
  logic [TW-1:0]      n_r, d1_r, d2_r, dl_r, dlast_r;
  tok_t               tok_r, tok_nxt;
  logic               tok_v_r;

  logic [SIZE_W-1:0] wsat, hsat;
  logic [TW-1:0]     n_new, wp1, d1_new, d2_new, dl_new, dlast_new;
  logic              start, make, accept;

  // saturate the frame size and derive the stage offsets
  always_comb begin
    if (width_r == '0) begin
      wsat = SIZE_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      wsat = SIZE_W'(MAX_WIDTH);
    end else begin
      wsat = width_r;
    end
    if (height_r == '0) begin
      hsat = SIZE_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      hsat = SIZE_W'(MAX_HEIGHT);
    end else begin
      hsat = height_r;
    end
    n_new     = TW'(wsat) * TW'(hsat);
    wp1       = TW'(wsat) + TW'(1);
    d1_new    = TW'(GROW_RADIUS) * wp1;
    d2_new    = TW'(GROW_RADIUS + SHRINK_RADIUS) * wp1;
    dl_new    = TW'(LAG_SUM) * wp1;
    dlast_new = dl_new + n_new - TW'(1);
  end

  assign start    = (t_r == '0);
  assign make     = start ? !in_action : ((t_r >= n_r) || !in_action);
  assign in_ready = !tok_v_r || tok_ready;
  assign accept   = in_valid && in_ready;

  // build the token of this tick
  always_comb begin
    tok_nxt = tok_r;
    if (start) begin
      tok_nxt.act   = (STAGE_CNT+1)'(1);
      tok_nxt.first = (STAGE_CNT+1)'(1);
      tok_nxt.outv  = 1'b0;
      tok_nxt.last  = 1'b0;
      tok_nxt.w     = wsat;
      tok_nxt.h     = hsat;
      tok_nxt.label = label_r;
      tok_nxt.mbit  = (in_pixel_color == label_r);
    end else begin
      tok_nxt.act   = {t_r >= dl_r, t_r >= d2_r, t_r >= d1_r, 1'b1};
      tok_nxt.first = {t_r == dl_r, t_r == d2_r, t_r == d1_r, 1'b0};
      tok_nxt.outv  = (t_r >= dl_r);
      tok_nxt.last  = (t_r == dlast_r);
      tok_nxt.w     = f_w_r;
      tok_nxt.h     = f_h_r;
      tok_nxt.label = f_label_r;
      tok_nxt.mbit  = (in_pixel_color == f_label_r);
    end
    t_nxt = tok_nxt.last ? '0 : t_r + TW'(1);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r  <= '0;
      width_r  <= RESET_SIZE;
      height_r <= RESET_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_LABEL:  label_r  <= cfg_wdata;
        CFG_IDX_WIDTH:  width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_IDX_HEIGHT: height_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // position, frame settings and token register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r       <= '0;
      tok_v_r   <= 1'b0;
      f_label_r <= '0;
      f_w_r     <= RESET_SIZE;
      f_h_r     <= RESET_SIZE;
      n_r       <= '0;
      d1_r      <= '0;
      d2_r      <= '0;
      dl_r      <= '0;
      dlast_r   <= '0;
    end else begin
      if (tok_v_r && tok_ready) begin
        tok_v_r <= 1'b0;
      end
      if (accept && make) begin
        tok_v_r <= 1'b1;
        t_r     <= t_nxt;
        if (start) begin
          f_label_r <= label_r;
          f_w_r     <= wsat;
          f_h_r     <= hsat;
          n_r       <= n_new;
          d1_r      <= d1_new;
          d2_r      <= d2_new;
          dl_r      <= dl_new;
          dlast_r   <= dlast_new;
        end
      end
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    if (accept && make) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_valid = tok_v_r;
  assign tok       = tok_r;

endmodule

FILE: src/lmcof_stage.sv
// ----------------------------------------------------------------------------
// lmcof_stage: one square morphology stage on the mask stream
// Column memory of the last 2R rows gives the vertical window, a tap line of
// 2R+1 column results gives the horizontal window; both clip to the frame.
// ----------------------------------------------------------------------------
module lmcof_stage import lmcof_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 3,
  parameter bit DILATE    = 1'b1,
  parameter int IDX       = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  tok_t up_tok,
  output logic dn_valid,
  input  logic dn_ready,
  output tok_t dn_tok
);

  localparam int WORD = 2 * RADIUS;
  localparam int TAPS = 2 * RADIUS + 1;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int EW   = SIZE_W + 1;

  logic [WORD-1:0]   mem [MAX_WIDTH];
  logic [WORD-1:0]   rd_r;
  logic [TAPS-1:0]   h_r, h_new;
  logic [SIZE_W-1:0] x_r, y_r, xc_r;
  logic              v_r;
  tok_t              tok_r, tok_nxt;

  logic              act, fin, oact, ofin, proc;
  logic [SIZE_W-1:0] x_cur, y_cur, x_adv, y_adv, xc_cur, xc_adv;
  logic              row_end;
  logic [WORD-1:0]   vld, wword;
  logic [TAPS-1:0]   inc;
  logic              cur_vld, vbit, hout;
  logic [AW-1:0]     wr_addr, rd_addr;

  assign act  = up_tok.act[IDX];
  assign fin  = up_tok.first[IDX];
  assign oact = up_tok.act[IDX+1];
  assign ofin = up_tok.first[IDX+1];

  assign up_ready = !v_r || dn_ready;
  assign proc     = up_valid && up_ready;

  // advance the column and row of the stage input
  always_comb begin
    x_cur   = fin ? '0 : x_r;
    y_cur   = fin ? '0 : y_r;
    row_end = (x_cur == up_tok.w - SIZE_W'(1));
    x_adv   = row_end ? '0 : x_cur + SIZE_W'(1);
    y_adv   = row_end ? y_cur + SIZE_W'(1) : y_cur;
    xc_cur  = ofin ? '0 : xc_r;
    xc_adv  = (xc_cur == up_tok.w - SIZE_W'(1)) ? '0 : xc_cur + SIZE_W'(1);
    wr_addr = AW'(x_cur);
    rd_addr = AW'(x_adv);
  end

  // vertical window over the column; rows outside the frame are neutral
  always_comb begin
    cur_vld = (y_cur < up_tok.h);
    for (int k = 0; k < WORD; k++) begin
      vld[k] = (y_cur > SIZE_W'(k)) &&
               ({1'b0, y_cur} < ({1'b0, up_tok.h} + EW'(k + 1)));
    end
    if (DILATE) begin
      vbit = (up_tok.mbit && cur_vld) || |(rd_r & vld);
    end else begin
      vbit = (up_tok.mbit || !cur_vld) && &(rd_r | ~vld);
    end
    wword = {rd_r[WORD-2:0], up_tok.mbit};
  end

  // horizontal window round the center column; drop taps of other rows
  always_comb begin
    h_new = {h_r[TAPS-2:0], vbit};
    for (int j = 0; j < TAPS; j++) begin
      if (j < RADIUS) begin
        inc[j] = (({1'b0, xc_cur} + EW'(RADIUS - j)) < {1'b0, up_tok.w});
      end else if (j > RADIUS) begin
        inc[j] = (xc_cur >= SIZE_W'(j - RADIUS));
      end else begin
        inc[j] = 1'b1;
      end
    end
    if (DILATE) begin
      hout = |(h_new & inc);
    end else begin
      hout = &(h_new | ~inc);
    end
    tok_nxt      = up_tok;
    tok_nxt.mbit = hout;
  end

  // column memory with prefetch of the next column
  always_ff @(posedge clk) begin
    if (proc && act) begin
      mem[wr_addr] <= wword;
      if (rd_addr == wr_addr) begin
        rd_r <= wword;
      end else begin
        rd_r <= mem[rd_addr];
      end
    end
  end

  // control: valid, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      x_r  <= '0;
      y_r  <= '0;
      xc_r <= '0;
    end else begin
      if (v_r && dn_ready) begin
        v_r <= 1'b0;
      end
      if (proc) begin
        v_r <= 1'b1;
        if (act) begin
          x_r <= x_adv;
          y_r <= y_adv;
        end
        if (oact) begin
          xc_r <= xc_adv;
        end
      end
    end
  end

  // tap line and result token
  always_ff @(posedge clk) begin
    if (proc) begin
      tok_r <= tok_nxt;
      if (act) begin
        h_r <= h_new;
      end
    end
  end

  assign dn_valid = v_r;
  assign dn_tok   = tok_r;

endmodule

FILE: src/label_mask_close_open_filter.sv
// ----------------------------------------------------------------------------
// label_mask_close_open_filter: dilate, erode, dilate on a label mask
// Path: a result is carried by the token register, which loads at the transfer
// of the tick that completes it, then by three stage registers and the output
// register. Pixel k of a frame is completed by tick k +
// (2*GROW_RADIUS + SHRINK_RADIUS) * (W + 1).
// Throughput: one tick per cycle when nothing stalls; each stage reads and
// writes its column memory once per tick (prefetch of the next column).
// Reset: clears control and loads register defaults; line memories are not
// cleared, rows outside the frame are masked by row position instead.
// ----------------------------------------------------------------------------
module label_mask_close_open_filter import lmcof_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int GROW_RADIUS   = 3,
  parameter int SHRINK_RADIUS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [COLOR_W-1:0]   in_pixel_color,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COLOR_W-1:0]   out_color,
  output logic                 out_frame_last
);

  tok_t tok0, tok1, tok2, tok3;
  logic v0, v1, v2, v3;
  logic r0, r1, r2, r3;

  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;
  logic               out_free, take3;

  lmcof_front #(
    .MAX_WIDTH(MAX_WIDTH), .GROW_RADIUS(GROW_RADIUS), .SHRINK_RADIUS(SHRINK_RADIUS)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_pixel_color(in_pixel_color),
    .tok_valid(v0), .tok_ready(r0), .tok(tok0)
  );

  lmcof_stage #(
    .MAX_WIDTH(MAX_WIDTH), .RADIUS(GROW_RADIUS), .DILATE(1'b1), .IDX(0)
  ) u_grow0 (
    .clk(clk), .rst_n(rst_n),
    .up_valid(v0), .up_ready(r0), .up_tok(tok0),
    .dn_valid(v1), .dn_ready(r1), .dn_tok(tok1)
  );

  lmcof_stage #(
    .MAX_WIDTH(MAX_WIDTH), .RADIUS(SHRINK_RADIUS), .DILATE(1'b0), .IDX(1)
  ) u_shrink (
    .clk(clk), .rst_n(rst_n),
    .up_valid(v1), .up_ready(r1), .up_tok(tok1),
    .dn_valid(v2), .dn_ready(r2), .dn_tok(tok2)
  );

  lmcof_stage #(
    .MAX_WIDTH(MAX_WIDTH), .RADIUS(GROW_RADIUS), .DILATE(1'b1), .IDX(2)
  ) u_grow1 (
    .clk(clk), .rst_n(rst_n),
    .up_valid(v2), .up_ready(r2), .up_tok(tok2),
    .dn_valid(v3), .dn_ready(r3), .dn_tok(tok3)
  );

  // drop ticks with no result, hold results in the output register
  assign out_free = !out_valid_r || out_ready;
  assign r3       = !tok3.outv || out_free;
  assign take3    = v3 && r3 && tok3.outv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= take3;
    end
  end

  always_ff @(posedge clk) begin
    if (take3) begin
      out_color_r <= tok3.mbit ? tok3.label : WHITE_COLOR;
      out_last_r  <= tok3.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_color      = out_color_r;
  assign out_frame_last = out_last_r;

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for label_mask_close_open_filter
// Sends frames of label pixels and their flush ticks, predicts every result
// with a behavioral copy of the dilate/erode/dilate mask filter, and compares
// each result transfer with the oldest predicted pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lmcof_pkg::*;

  localparam bit ACT_PIXEL = 1'b0;
  localparam bit ACT_FLUSH = 1'b1;
  localparam int GROW      = 3;
  localparam int SHRINK    = 6;
  localparam int LINE_MAX  = 1024;
  localparam int RING      = 64;
  localparam int STAGE_RAW = 0;
  localparam int STAGE_DIL = 1;
  localparam int STAGE_ERO = 2;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_out_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_action;
  logic [COLOR_W-1:0]   in_pixel_color;
  logic                 out_valid;
  logic                 out_ready;
  logic [COLOR_W-1:0]   out_color;
  logic                 out_frame_last;

  label_mask_close_open_filter dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_action, .in_pixel_color,
    .out_valid, .out_ready, .out_color, .out_frame_last
  );

  // Predictor state
  bit           raw_mask [RING*LINE_MAX];
  bit           dil_mask [RING*LINE_MAX];
  bit           ero_mask [RING*LINE_MAX];
  int           tick_pos;
  logic [23:0]  reg_label;
  logic [10:0]  reg_width;
  logic [10:0]  reg_height;
  logic [23:0]  frame_label;
  int           frame_w;
  int           frame_h;
  pixel_out_t   pending_pixels[$];

  int errors;
  int counted_items;
  int burst_left;
  bit gaps_on;
  int ready_pct;
  bit hold_start;
  int hold_cnt;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int clamp_size(logic [10:0] v);
    if (v < 1) return 1;
    if (v > LINE_MAX) return LINE_MAX;
    return int'(v);
  endfunction

  function automatic int slot(int y, int x);
    return (y % RING) * LINE_MAX + (x % LINE_MAX);
  endfunction

  // Max (all=0) or min (all=1) of a square window clipped to the frame
  function automatic bit window_reduce(int stage, int p, int r, bit all);
    int y, x, ylo, yhi, xlo, xhi;
    bit b;
    y   = p / frame_w;
    x   = p % frame_w;
    ylo = (y >= r) ? y - r : 0;
    yhi = (y + r < frame_h) ? y + r : frame_h - 1;
    xlo = (x >= r) ? x - r : 0;
    xhi = (x + r < frame_w) ? x + r : frame_w - 1;
    for (int yy = ylo; yy <= yhi; yy++) begin
      for (int xx = xlo; xx <= xhi; xx++) begin
        case (stage)
          STAGE_RAW: b = raw_mask[slot(yy, xx)];
          STAGE_DIL: b = dil_mask[slot(yy, xx)];
          default:   b = ero_mask[slot(yy, xx)];
        endcase
        if (all && !b) return 1'b0;
        if (!all && b) return 1'b1;
      end
    end
    return all;
  endfunction

  // Advance the filter by one tick; returns 0 when the tick is dropped
  function automatic bit filter_tick(bit act, logic [23:0] color);
    int t, n, d1, d2, dl, p;
    pixel_out_t r;
    t = tick_pos;
    if (t == 0) begin
      if (act) return 1'b0;
      frame_label = reg_label;
      frame_w     = clamp_size(reg_width);
      frame_h     = clamp_size(reg_height);
    end
    n = frame_w * frame_h;
    if (t < n) begin
      if (act) return 1'b0;
      raw_mask[slot(t / frame_w, t % frame_w)] = (color == frame_label);
    end
    d1 = GROW * (frame_w + 1);
    d2 = (GROW + SHRINK) * (frame_w + 1);
    dl = (2 * GROW + SHRINK) * (frame_w + 1);
    if (t >= d1 && t - d1 < n)
      dil_mask[slot((t - d1) / frame_w, (t - d1) % frame_w)] =
        window_reduce(STAGE_RAW, t - d1, GROW, 1'b0);
    if (t >= d2 && t - d2 < n)
      ero_mask[slot((t - d2) / frame_w, (t - d2) % frame_w)] =
        window_reduce(STAGE_DIL, t - d2, SHRINK, 1'b1);
    tick_pos = t + 1;
    if (t >= dl && t - dl < n) begin
      p       = t - dl;
      r.color = window_reduce(STAGE_ERO, p, GROW, 1'b0) ? frame_label : WHITE_COLOR;
      r.last  = (p == n - 1);
      pending_pixels.insert(pending_pixels.size(), r);
      if (p == n - 1) tick_pos = 0;
    end
    return 1'b1;
  endfunction

  // Receiver: own stall pattern plus an on-demand long hold-off
  always @(posedge clk) begin
    if (hold_start) begin
      hold_cnt   = 300;
      hold_start = 1'b0;
    end
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt--;
    end else begin
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Compare each result transfer with the oldest predicted pixel
  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result color=%h last=%b", $time, out_color,
                 out_frame_last);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_color !== exp_px.color) begin
          $display("%0t: color mismatch expected=%h actual=%h", $time,
                   exp_px.color, out_color);
          errors++;
        end
        if (out_frame_last !== exp_px.last) begin
          $display("%0t: frame_last mismatch expected=%b actual=%b", $time,
                   exp_px.last, out_frame_last);
          errors++;
        end
      end
    end
  end

  task automatic wait_drain();
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Write one register once the block has gone quiet
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    in_valid <= 1'b0;
    burst_left = 0;
    wait_drain();
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IDX_LABEL:  reg_label  = val;
      CFG_IDX_WIDTH:  reg_width  = val[10:0];
      CFG_IDX_HEIGHT: reg_height = val[10:0];
      default: ;
    endcase
  endtask

  // Offer one tick and hold it until the transfer
  task automatic send_tick(bit act, logic [23:0] color);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_pixel_color <= color;
    do @(posedge clk); while (!in_ready);
    if (filter_tick(act, color)) counted_items++;
    if (burst_left > 0) burst_left--;
  endtask

  function automatic logic [23:0] pick_color(logic [23:0] lbl, int hit_pct);
    if ($urandom_range(0, 99) < hit_pct) return lbl;
    if ($urandom_range(0, 1)) return lbl ^ (24'd1 << $urandom_range(0, 23));
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  // One frame: program label and sizes, send pixels, then enough flush ticks to empty it
  task automatic run_frame(logic [10:0] w, logic [10:0] h, logic [23:0] lbl,
                           int hit_pct, bit noisy);
    int n, ticks;
    cfg_write(CFG_IDX_LABEL, lbl);
    cfg_write(CFG_IDX_WIDTH, 24'(w));
    cfg_write(CFG_IDX_HEIGHT, 24'(h));
    n     = clamp_size(w) * clamp_size(h);
    ticks = (2 * GROW + SHRINK) * (clamp_size(w) + 1);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 99) < 3)
        send_tick(ACT_FLUSH, 24'($urandom_range(0, 24'hFFFFFF)));
      send_tick(ACT_PIXEL, pick_color(lbl, hit_pct));
    end
    for (int i = 0; i < ticks; i++) begin
      // a pixel past the frame end counts as a flush
      if (noisy && $urandom_range(0, 99) < 20)
        send_tick(ACT_PIXEL, 24'($urandom_range(0, 24'hFFFFFF)));
      else
        send_tick(ACT_FLUSH, 24'($urandom_range(0, 24'hFFFFFF)));
    end
  endtask

  task automatic test_idle_flush();
    send_tick(ACT_FLUSH, 24'hFFFFFF);
    send_tick(ACT_FLUSH, 24'h000000);
    run_frame(11'd1, 11'd1, 24'h000000, 100, 1'b0);
  endtask

  task automatic test_small_extremes();
    run_frame(11'd0, 11'd0, 24'hFFFFFF, 50, 1'b0);
    run_frame(11'd3, 11'd3, WHITE_COLOR, 50, 1'b0);
    run_frame(11'd2, 11'd2, 24'h000000, 0, 1'b0);
  endtask

  task automatic test_wide_row();
    run_frame(11'd10, 11'd1, 24'h5A5A5A, 50, 1'b0);
  endtask

  task automatic test_tall_column();
    run_frame(11'd1, 11'd20, 24'hA5A5A5, 50, 1'b0);
  endtask

  task automatic test_backpressure();
    gaps_on   = 1'b0;
    ready_pct = 100;
    in_valid <= 1'b0;
    wait_drain();
    hold_start = 1'b1;
    run_frame(11'd4, 11'd8, 24'($urandom_range(0, 24'hFFFFFF)), 70, 1'b0);
    in_valid <= 1'b0;
    wait_drain();
    gaps_on   = 1'b1;
    ready_pct = 70;
  endtask

  task automatic test_random_frames();
    int start_count;
    start_count = counted_items;
    while (counted_items - start_count < 80) begin
      ready_pct = $urandom_range(0, 3) == 0 ? 100 : $urandom_range(30, 95);
      gaps_on   = $urandom_range(0, 3) != 0;
      run_frame(11'($urandom_range(1, 6)), 11'($urandom_range(1, 6)),
                24'($urandom_range(0, 24'hFFFFFF)), $urandom_range(0, 100),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    errors         = 0;
    counted_items  = 0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    ready_pct      = 70;
    hold_start     = 1'b0;
    hold_cnt       = 0;
    tick_pos       = 0;
    reg_label      = '0;
    reg_width      = RESET_SIZE;
    reg_height     = RESET_SIZE;
    frame_label    = '0;
    frame_w        = LINE_MAX;
    frame_h        = LINE_MAX;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_IDX_LABEL;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_action      <= ACT_PIXEL;
    in_pixel_color <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_flush();
    test_small_extremes();
    test_wide_row();
    test_tall_column();
    test_backpressure();
    test_random_frames();

    in_valid <= 1'b0;
    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
